FILE: rtl/core/g1alu_pkg.sv
// ----------------------------------------------------------------------------
// g1alu_pkg
// Types, codes and helpers shared by the group-1 ALU, its datapath and its bench.
// ----------------------------------------------------------------------------
package g1alu_pkg;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_OR  = 3'd1,
    OP_ADC = 3'd2,
    OP_SBB = 3'd3,
    OP_AND = 3'd4,
    OP_SUB = 3'd5,
    OP_XOR = 3'd6,
    OP_CMP = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    SZ_BYTE  = 2'd0,
    SZ_WORD  = 2'd1,
    SZ_DWORD = 2'd2,
    SZ_QWORD = 2'd3
  } size_e;

  typedef enum logic [1:0] {
    IMM_1B = 2'd0,
    IMM_2B = 2'd1,
    IMM_4B = 2'd2,
    IMM_8B = 2'd3
  } imm_width_e;

  // Stored flag order: bit0 CF up to bit5 OF
  typedef struct packed {
    logic of;
    logic sf;
    logic zf;
    logic af;
    logic pf;
    logic cf;
  } flags_t;

  typedef struct packed {
    logic [63:0] value;
    logic        write_back;
    flags_t      flags;
  } result_t;

  function automatic logic [63:0] size_mask(input size_e sz);
    logic [63:0] m;
    case (sz)
      SZ_BYTE:  m = 64'h0000_0000_0000_00FF;
      SZ_WORD:  m = 64'h0000_0000_0000_FFFF;
      SZ_DWORD: m = 64'h0000_0000_FFFF_FFFF;
      default:  m = 64'hFFFF_FFFF_FFFF_FFFF;
    endcase
    return m;
  endfunction

  function automatic logic top_bit(input logic [63:0] v, input size_e sz);
    logic b;
    case (sz)
      SZ_BYTE:  b = v[7];
      SZ_WORD:  b = v[15];
      SZ_DWORD: b = v[31];
      default:  b = v[63];
    endcase
    return b;
  endfunction

  function automatic logic [63:0] sext_imm(input logic [63:0] raw, input imm_width_e w);
    logic [63:0] v;
    case (w)
      IMM_1B:  v = {{56{raw[7]}}, raw[7:0]};
      IMM_2B:  v = {{48{raw[15]}}, raw[15:0]};
      IMM_4B:  v = {{32{raw[31]}}, raw[31:0]};
      default: v = raw;
    endcase
    return v;
  endfunction

endpackage

FILE: rtl/core/g1alu_req_if.sv
// ----------------------------------------------------------------------------
// g1alu_req_if
// Request channel: operation, sizes and operands, with valid/ready.
// ----------------------------------------------------------------------------
interface g1alu_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  operation;
  logic [1:0]  operand_size;
  logic [63:0] dest_value;
  logic [63:0] imm_raw;
  logic [1:0]  imm_width;

  modport source (
    output valid, operation, operand_size, dest_value, imm_raw, imm_width,
    input  ready
  );
  modport sink (
    input  valid, operation, operand_size, dest_value, imm_raw, imm_width,
    output ready
  );
endinterface

FILE: rtl/core/g1alu_rsp_if.sv
// ----------------------------------------------------------------------------
// g1alu_rsp_if
// Result channel: masked result, write-back strobe and flags, valid/ready.
// ----------------------------------------------------------------------------
interface g1alu_rsp_if;
  logic        valid;
  logic        ready;
  logic [63:0] result_value;
  logic        write_back;
  logic        carry_flag;
  logic        parity_flag;
  logic        aux_flag;
  logic        zero_flag;
  logic        sign_flag;
  logic        overflow_flag;

  modport source (
    output valid, result_value, write_back, carry_flag, parity_flag, aux_flag,
           zero_flag, sign_flag, overflow_flag,
    input  ready
  );
  modport sink (
    input  valid, result_value, write_back, carry_flag, parity_flag, aux_flag,
           zero_flag, sign_flag, overflow_flag,
    output ready
  );
endinterface

FILE: rtl/core/g1alu_exec.sv
// ----------------------------------------------------------------------------
// g1alu_exec
// Combinational datapath: operand masking, shared adder/subtractor,
// logic ops and flag generation for one request.
// ----------------------------------------------------------------------------
module g1alu_exec
  import g1alu_pkg::*;
(
  input  op_e         op_i,
  input  size_e       size_i,
  input  logic [63:0] dest_i,
  input  logic [63:0] imm_raw_i,
  input  imm_width_e  imm_width_i,
  input  flags_t      flags_i,
  output result_t     res_o
);

  logic [63:0] mask;
  logic [63:0] a;
  logic [63:0] b;
  logic [63:0] b_add;
  logic        is_arith;
  logic        is_sub;
  logic        use_cin;
  logic        add_cin;
  logic [63:0] sum;
  logic [63:0] r;
  flags_t      fl;

  assign mask = size_mask(size_i);
  assign a    = dest_i & mask;
  assign b    = sext_imm(imm_raw_i, imm_width_i) & mask;

  assign is_sub   = op_i inside {OP_SBB, OP_SUB, OP_CMP};
  assign is_arith = is_sub || (op_i == OP_ADD) || (op_i == OP_ADC);
  assign use_cin  = (op_i == OP_ADC) || (op_i == OP_SBB);

  // a - b - c is done as a + ~b + !c
  assign b_add   = is_sub ? ~b : b;
  assign add_cin = is_sub ? ~(use_cin & flags_i.cf) : (use_cin & flags_i.cf);
  assign sum     = a + b_add + {63'd0, add_cin};

  always_comb begin
    r = '0;
    case (op_i)
      OP_OR:   r = a | b;
      OP_AND:  r = a & b;
      OP_XOR:  r = a ^ b;
      default: r = sum & mask;
    endcase
  end

  always_comb begin
    fl    = '0;
    fl.pf = ~^r[7:0];
    fl.zf = (r == 64'd0);
    fl.sf = top_bit(r, size_i);
    if (!is_arith) begin
      fl.cf = 1'b0;
      fl.of = 1'b0;
      fl.af = flags_i.af;
    end else if (is_sub) begin
      fl.cf = top_bit((~a & b) | ((~a | b) & r), size_i);
      fl.of = top_bit((a ^ b) & (a ^ r), size_i);
      fl.af = a[4] ^ b[4] ^ r[4];
    end else begin
      fl.cf = top_bit((a & b) | ((a | b) & ~r), size_i);
      fl.of = top_bit((a ^ r) & (b ^ r), size_i);
      fl.af = a[4] ^ b[4] ^ r[4];
    end
  end

  assign res_o.value      = r;
  assign res_o.write_back = (op_i != OP_CMP);
  assign res_o.flags      = fl;

endmodule

FILE: rtl/core/x86_group1_alu_with_flags.sv
// ----------------------------------------------------------------------------
// x86_group1_alu_with_flags
// Group-1 immediate ALU (ADD/OR/ADC/SBB/AND/SUB/XOR/CMP) with stored flags.
//
// One request is taken per cycle unless the request side stalls. Each request is
// registered in the first stage, evaluated in a single pass through the 64-bit
// adder and flag logic, and captured in the result register. The six arithmetic
// flags are updated as each request leaves the first stage, so ADC/SBB see the
// carry of the request before them with no extra delay.
// Results are masked to the operand size; CMP returns the difference with
// write_back low. The request side stalls only when both stages hold work
// and the result is not taken.
// ----------------------------------------------------------------------------
module x86_group1_alu_with_flags
  import g1alu_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  g1alu_req_if.sink    req_i,
  g1alu_rsp_if.source  rsp_o
);

  logic        s1_vld_q;
  op_e         s1_op_q;
  size_e       s1_size_q;
  logic [63:0] s1_dest_q;
  logic [63:0] s1_imm_q;
  imm_width_e  s1_immw_q;

  logic        out_vld_q;
  result_t     out_q;
  flags_t      flags_q;

  result_t     res;
  logic        adv;
  logic        req_acc;

  assign adv     = s1_vld_q && (!out_vld_q || rsp_o.ready);
  assign req_acc = req_i.valid && req_i.ready;

  assign req_i.ready = !s1_vld_q || adv;

  g1alu_exec u_exec (
    .op_i        (s1_op_q),
    .size_i      (s1_size_q),
    .dest_i      (s1_dest_q),
    .imm_raw_i   (s1_imm_q),
    .imm_width_i (s1_immw_q),
    .flags_i     (flags_q),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      flags_q   <= '0;
    end else begin
      if (req_i.ready) begin
        s1_vld_q <= req_i.valid;
      end
      if (adv) begin
        out_vld_q <= 1'b1;
        flags_q   <= res.flags;
      end else if (rsp_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      s1_op_q   <= op_e'(req_i.operation);
      s1_size_q <= size_e'(req_i.operand_size);
      s1_dest_q <= req_i.dest_value;
      s1_imm_q  <= req_i.imm_raw;
      s1_immw_q <= imm_width_e'(req_i.imm_width);
    end
    if (adv) begin
      out_q <= res;
    end
  end

  assign rsp_o.valid         = out_vld_q;
  assign rsp_o.result_value  = out_q.value;
  assign rsp_o.write_back    = out_q.write_back;
  assign rsp_o.carry_flag    = out_q.flags.cf;
  assign rsp_o.parity_flag   = out_q.flags.pf;
  assign rsp_o.aux_flag      = out_q.flags.af;
  assign rsp_o.zero_flag     = out_q.flags.zf;
  assign rsp_o.sign_flag     = out_q.flags.sf;
  assign rsp_o.overflow_flag = out_q.flags.of;

`ifndef SYNTHESIS
  // stored flags always track the latest result issued
  a_flags_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> (flags_q == out_q.flags))
    else $error("flag register out of step with result");

  // logic ops never set CF or OF
  a_logic_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && (s1_op_q == OP_OR || s1_op_q == OP_AND || s1_op_q == OP_XOR))
      |=> (!rsp_o.carry_flag && !rsp_o.overflow_flag))
    else $error("logical op produced CF or OF");

  // a held first stage is never dropped
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_vld_q && !adv) |=> s1_vld_q)
    else $error("stalled request lost");

  // CMP result never writes back
  a_cmp_nowb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && s1_op_q == OP_CMP) |=> !rsp_o.write_back)
    else $error("compare flagged for write-back");
`endif

endmodule

FILE: tb/x86_group1_alu_with_flags_test.sv
// ----------------------------------------------------------------------------
// x86_group1_alu_with_flags_test
// Self-checking bench for the group-1 immediate ALU. Each accepted request is
// run through a behavioural model of the ALU and its stored flags, and each
// returned result is compared field by field with the oldest prediction.
// A directed set covers boundary cases, then about a thousand random requests
// follow, with random idling on both sides, a long result hold-off and a
// full drain part-way through.
// ----------------------------------------------------------------------------
module x86_group1_alu_with_flags_test;
  import g1alu_pkg::*;

  localparam int unsigned RANDOM_REQUESTS = 1000;
  localparam int unsigned CYCLE_LIMIT     = 200000;
  localparam int unsigned DRAIN_CYCLES    = 8;
  localparam int unsigned HOLD_OFF_CYCLES = 60;
  localparam int unsigned IDLE_PERCENT    = 23;

  class AluFlagScoreboard;
    flags_t      held_flags;
    result_t     pending[$];
    int unsigned mismatches;
    int unsigned matched;

    function new();
      held_flags = '0;
      mismatches = 0;
      matched    = 0;
    endfunction

    function logic [63:0] widen_imm(logic [63:0] raw, imm_width_e w);
      logic signed [63:0] t;
      int unsigned        shift;
      case (w)
        IMM_1B:  shift = 56;
        IMM_2B:  shift = 48;
        IMM_4B:  shift = 32;
        default: shift = 0;
      endcase
      t = raw << shift;
      t = t >>> shift;
      return t;
    endfunction

    // Predict the result of one accepted request and advance the flag state
    function void note_request(op_e op, size_e sz, logic [63:0] dest,
                               logic [63:0] imm, imm_width_e iw);
      logic [63:0] m, a, b, r, cy;
      logic        cin, cf, of, af;
      int unsigned top;
      result_t     res;
      case (sz)
        SZ_BYTE:  begin m = 64'hFF;        top = 7;  end
        SZ_WORD:  begin m = 64'hFFFF;      top = 15; end
        SZ_DWORD: begin m = 64'hFFFF_FFFF; top = 31; end
        default:  begin m = '1;            top = 63; end
      endcase
      a   = dest & m;
      b   = widen_imm(imm, iw) & m;
      cin = held_flags.cf;
      cf  = 1'b0;
      of  = 1'b0;
      af  = held_flags.af;  // logical ops keep AF
      r   = '0;
      case (op)
        OP_ADD, OP_ADC: begin
          if (op == OP_ADD) cin = 1'b0;
          r  = (a + b + {63'd0, cin}) & m;
          cy = (a & b) | ((a | b) & ~r);
          cf = cy[top];
          cy = (a ^ r) & (b ^ r);
          of = cy[top];
          cy = a ^ b ^ r;
          af = cy[4];
        end
        OP_SUB, OP_SBB, OP_CMP: begin
          if (op != OP_SBB) cin = 1'b0;
          r  = (a - b - {63'd0, cin}) & m;
          cy = (~a & b) | ((~a | b) & r);
          cf = cy[top];
          cy = (a ^ b) & (a ^ r);
          of = cy[top];
          cy = a ^ b ^ r;
          af = cy[4];
        end
        OP_OR:   r = a | b;
        OP_AND:  r = a & b;
        default: r = a ^ b;
      endcase
      res.value      = r;
      res.write_back = (op != OP_CMP);
      res.flags.cf   = cf;
      res.flags.pf   = ~^r[7:0];
      res.flags.af   = af;
      res.flags.zf   = (r == 64'd0);
      res.flags.sf   = r[top];
      res.flags.of   = of;
      held_flags     = res.flags;
      pending.push_back(res);
    endfunction

    function void field_error(string field, logic [63:0] want, logic [63:0] got);
      mismatches++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        return;
      end
      want = pending.pop_front();
      if (got === want) begin
        matched++;
        return;
      end
      if (got.value !== want.value) field_error("result_value", want.value, got.value);
      if (got.write_back !== want.write_back)
        field_error("write_back", want.write_back, got.write_back);
      if (got.flags.cf !== want.flags.cf) field_error("carry_flag", want.flags.cf, got.flags.cf);
      if (got.flags.pf !== want.flags.pf)
        field_error("parity_flag", want.flags.pf, got.flags.pf);
      if (got.flags.af !== want.flags.af) field_error("aux_flag", want.flags.af, got.flags.af);
      if (got.flags.zf !== want.flags.zf) field_error("zero_flag", want.flags.zf, got.flags.zf);
      if (got.flags.sf !== want.flags.sf) field_error("sign_flag", want.flags.sf, got.flags.sf);
      if (got.flags.of !== want.flags.of)
        field_error("overflow_flag", want.flags.of, got.flags.of);
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  g1alu_req_if req_if ();
  g1alu_rsp_if rsp_if ();

  x86_group1_alu_with_flags DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  AluFlagScoreboard scoreboard = new();

  bit          steady       = 1'b0;  // no idling on either side while set
  bit          hold_off_due = 1'b0;
  int unsigned op_tally[8];

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  task automatic issue_request(input op_e op, input size_e sz, input logic [63:0] dest,
                               input logic [63:0] imm, input imm_width_e iw);
    // each cycle idles on its own draw
    while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid        <= 1'b1;
    req_if.operation    <= op;
    req_if.operand_size <= sz;
    req_if.dest_value   <= dest;
    req_if.imm_raw      <= imm;
    req_if.imm_width    <= iw;
    do @(posedge clk_i); while (!req_if.ready);
    scoreboard.note_request(op, sz, dest, imm, iw);
    op_tally[op]++;
  endtask

  task automatic issue_random();
    op_e         op;
    size_e       sz;
    imm_width_e  iw;
    logic [63:0] dest;
    logic [63:0] imm;
    op   = op_e'($urandom_range(7));
    sz   = size_e'($urandom_range(3));
    iw   = imm_width_e'($urandom_range(3));
    dest = {$urandom, $urandom};
    imm  = {$urandom, $urandom};
    // lane-repeated patterns hit sign and carry boundaries at every size
    case ($urandom_range(11))
      0: dest = '0;
      1: dest = '1;
      2: dest = {8{8'h80}};
      3: dest = {8{8'h7F}};
      4: dest = {16{4'hF}} ^ {16{4'h1}};
      default: ;
    endcase
    case ($urandom_range(11))
      0: imm = '0;
      1: imm = '1;
      2: imm = {8{8'h80}};
      3: imm = {8{8'h7F}};
      4: begin
        imm = dest;  // equal operands give zero results for SUB, CMP and XOR
        iw  = IMM_8B;
      end
      default: ;
    endcase
    issue_request(op, sz, dest, imm, iw);
  endtask

  task automatic await_results();
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (scoreboard.pending.size() != 0);
  endtask

  task automatic run_directed();
    issue_request(OP_ADD, SZ_BYTE,  64'hDEAD_BEEF_CAFE_00FF, 64'h01, IMM_1B);
    issue_request(OP_ADC, SZ_BYTE,  64'h7F, 64'hFFFF_FF00, IMM_1B);
    issue_request(OP_ADD, SZ_WORD,  64'h7FFF, 64'h1, IMM_2B);
    issue_request(OP_ADD, SZ_BYTE,  64'hFF, 64'h1, IMM_1B);
    issue_request(OP_SBB, SZ_WORD,  64'h0, 64'h0, IMM_2B);
    issue_request(OP_SUB, SZ_DWORD, 64'h8000_0000, 64'h1, IMM_1B);
    issue_request(OP_SUB, SZ_DWORD, 64'h0, 64'h80, IMM_1B);
    issue_request(OP_CMP, SZ_QWORD, '1, '1, IMM_8B);
    issue_request(OP_CMP, SZ_BYTE,  64'hFFFF_FF10, 64'h20, IMM_1B);
    // AF set here must survive the logical requests that follow
    issue_request(OP_ADD, SZ_BYTE,  64'h0F, 64'h01, IMM_1B);
    issue_request(OP_OR,  SZ_WORD,  64'h1234_0000, 64'hFFFF_0000_00C0, IMM_1B);
    issue_request(OP_AND, SZ_DWORD, '1, 64'h5555_5555_8000_0000, IMM_4B);
    issue_request(OP_XOR, SZ_QWORD, '1, 64'hAAAA_AAAA_AAAA_8001, IMM_2B);
    issue_request(OP_ADD, SZ_QWORD, 64'h0, 64'h1234_5678_9ABC_DE80, IMM_1B);
    issue_request(OP_ADD, SZ_QWORD, '1, '1, IMM_8B);
    issue_request(OP_ADC, SZ_QWORD, 64'h7FFF_FFFF_FFFF_FFFF, 64'h0, IMM_8B);
    issue_request(OP_SBB, SZ_QWORD, 64'h0, '1, IMM_8B);
    issue_request(OP_SBB, SZ_BYTE,  64'h80, 64'h0, IMM_4B);
    issue_request(OP_XOR, SZ_BYTE,  64'h55, 64'hFF55, IMM_1B);
    issue_request(OP_AND, SZ_QWORD, 64'h8000_0000_0000_0000, '1, IMM_8B);
    issue_request(OP_OR,  SZ_BYTE,  64'hFFFF_FFFF_FFFF_FF00, 64'hFFFF_FFFF_FFFF_FF00, IMM_1B);
    issue_request(OP_SUB, SZ_WORD,  64'h8000, 64'hFFFF_0001, IMM_2B);
    issue_request(OP_CMP, SZ_DWORD, 64'h0, 64'h0, IMM_4B);
  endtask

  // Result side: check on handshake, then pick ready for the next edge
  initial begin
    int unsigned hold_left;
    result_t     got;
    hold_left = 0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && rsp_if.valid && rsp_if.ready) begin
        got.value      = rsp_if.result_value;
        got.write_back = rsp_if.write_back;
        got.flags.cf   = rsp_if.carry_flag;
        got.flags.pf   = rsp_if.parity_flag;
        got.flags.af   = rsp_if.aux_flag;
        got.flags.zf   = rsp_if.zero_flag;
        got.flags.sf   = rsp_if.sign_flag;
        got.flags.of   = rsp_if.overflow_flag;
        scoreboard.check_result(got);
      end
      if (hold_off_due) begin
        hold_left    = HOLD_OFF_CYCLES;
        hold_off_due = 1'b0;
      end
      if (hold_left != 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
      end
    end
  end

  initial begin
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("%0t: run timed out after %0d cycles", $time, cycles);
    $display("** x86_group1_alu_with_flags: FAILED **");
    $finish;
  end

  initial begin
    rst_ni              <= 1'b0;
    req_if.valid        <= 1'b0;
    req_if.operation    <= OP_ADD;
    req_if.operand_size <= SZ_BYTE;
    req_if.dest_value   <= '0;
    req_if.imm_raw      <= '0;
    req_if.imm_width    <= IMM_1B;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();

    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      steady = (n >= 400 && n < 550);
      if (n == 250) hold_off_due = 1'b1;  // sender keeps offering meanwhile
      if (n == 700) await_results();
      issue_random();
    end
    steady = 1'b0;
    await_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Checked %0d results against %0d predicted, %0d field mismatches",
             scoreboard.matched, scoreboard.matched + scoreboard.mismatches,
             scoreboard.mismatches);
    $display("Requests add %0d or %0d adc %0d sbb %0d and %0d sub %0d xor %0d cmp %0d",
             op_tally[OP_ADD], op_tally[OP_OR], op_tally[OP_ADC], op_tally[OP_SBB],
             op_tally[OP_AND], op_tally[OP_SUB], op_tally[OP_XOR], op_tally[OP_CMP]);
    if (scoreboard.mismatches == 0 && scoreboard.pending.size() == 0) begin
      $display("** x86_group1_alu_with_flags: PASSED **");
    end else begin
      $display("** x86_group1_alu_with_flags: FAILED **");
    end
    $finish;
  end

endmodule

FILE: x86_group1_alu_with_flags.f
rtl/core/g1alu_pkg.sv
rtl/core/g1alu_req_if.sv
rtl/core/g1alu_rsp_if.sv
rtl/core/g1alu_exec.sv
rtl/core/x86_group1_alu_with_flags.sv
tb/x86_group1_alu_with_flags_test.sv
